// ===== hw/rtl/slot_bitmap_allocator_top_assert.svh =====
// assertion macros for the slot bitmap allocator checker
// expects clk and arst_n in the scope of each use
`ifndef SLOT_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define SLOT_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// clocked check, off during reset
`define SBA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("slot bitmap allocator check failed");

// clocked check that also runs during reset
`define SBA_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("slot bitmap allocator check failed");

`endif

// ===== hw/rtl/sba_pkg.sv =====
// shared types and codes for the slot bitmap allocator
// no dependencies
`default_nettype none

package sba_pkg;

	localparam int MAP_BYTES_DEF = 32;

	localparam logic [5:0] MAP_BYTES_RST  = 6'd32;
	localparam logic [8:0] SLOT_COUNT_RST = 9'd256;

	typedef enum logic [1:0] {
		KIND_CLAIM   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_QUERY   = 2'd2,
		KIND_SPARE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SAME  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic {
		REG_MAP_BYTES  = 1'b0,
		REG_SLOT_COUNT = 1'b1
	} reg_idx_t;

	// word traveling down the cell chain
	typedef struct packed {
		logic       vld;
		logic       upd;
		logic       rel;
		logic [5:0] byte_sel;
		logic [2:0] bit_pos;
		status_t    status;
		logic       found;
		logic [8:0] first;
		logic       free_seen;
	} scan_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slot_bitmap_allocator_top.sv =====
// Slot bitmap allocator: keeps one occupancy bit per record slot in a chain
// of MAP_BYTES byte cells. A request is taken when start is high and busy is
// low; a word then walks the chain one cell per clock, each cell applying the
// claim or release if it owns the slot and adding its byte to the first-free
// and full search. The result appears on done for a single cycle once the
// word has passed launch_q and all cell registers, and cannot be held off;
// busy drops the cycle after, so requests never overlap. The map is cleared
// by reset. Configuration goes in through cfg_we / cfg_idx / cfg_wdata; the
// user must write it only while busy is low, as the block does not check.
`default_nettype none

module slot_bitmap_allocator_top #(
	parameter int MAP_BYTES = sba_pkg::MAP_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_idx,
	input  wire logic [8:0] cfg_wdata,
	input  wire logic       start,
	input  wire logic [1:0] kind,
	input  wire logic [8:0] slot_number,
	output logic            busy,
	output logic            done,
	output logic [1:0]      status,
	output logic [8:0]      first_free,
	output logic            full_res
);
	import sba_pkg::*;

	localparam logic [7:0] MAP_LIM = 8'(MAP_BYTES);

	logic [5:0] map_bytes_q;
	logic [8:0] slot_count_q;
	logic       busy_q;
	scan_t      launch_q;
	scan_t      link [MAP_BYTES + 1];

	logic       accept;
	logic       is_upd;
	logic [8:0] slot_idx;
	logic       in_range;
	scan_t      launch_nxt;

	always_comb begin
		accept   = start && !busy_q;
		is_upd   = (kind == KIND_CLAIM) || (kind == KIND_RELEASE);
		slot_idx = slot_number - 9'd1;
		in_range = (slot_number != 9'd0) && ({2'b0, slot_idx[8:3]} < MAP_LIM)
			&& (slot_idx[8:3] < map_bytes_q);

		launch_nxt           = '0;
		launch_nxt.vld       = accept;
		launch_nxt.upd       = is_upd && in_range;
		launch_nxt.rel       = kind == KIND_RELEASE;
		launch_nxt.byte_sel  = slot_idx[8:3];
		launch_nxt.bit_pos   = slot_idx[2:0];
		launch_nxt.status    = (is_upd && !in_range) ? ST_RANGE : ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_bytes_q  <= MAP_BYTES_RST;
			slot_count_q <= SLOT_COUNT_RST;
			busy_q       <= 1'b0;
			launch_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_idx))
					REG_MAP_BYTES:  map_bytes_q  <= cfg_wdata[5:0];
					REG_SLOT_COUNT: slot_count_q <= cfg_wdata;
				endcase
			end
			launch_q <= launch_nxt;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (link[MAP_BYTES].vld) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign link[0] = launch_q;

	for (genvar i = 0; i < MAP_BYTES; i++) begin : g_cell
		sba_cell #(
			.CELL_IDX(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.map_bytes (map_bytes_q),
			.slot_count(slot_count_q),
			.scan_in   (link[i]),
			.scan_out  (link[i + 1])
		);
	end

	assign busy       = busy_q;
	assign done       = link[MAP_BYTES].vld;
	assign status     = link[MAP_BYTES].status;
	assign first_free = link[MAP_BYTES].first;
	assign full_res   = !link[MAP_BYTES].free_seen;

endmodule

`default_nettype wire

// ===== hw/rtl/sba_cell.sv =====
// one byte of the occupancy map with its share of the search
// depends on sba_pkg
`default_nettype none

module sba_cell #(
	parameter int CELL_IDX = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [5:0]    map_bytes,
	input  wire logic [8:0]    slot_count,
	input  wire sba_pkg::scan_t scan_in,
	output sba_pkg::scan_t     scan_out
);
	import sba_pkg::*;

	localparam logic [9:0] BASE = 10'(CELL_IDX * 8);
	localparam logic [6:0] IDX7 = 7'(CELL_IDX);

	logic [7:0] byte_q;
	scan_t      scan_q;

	logic       hit;
	logic [7:0] bit_m;
	logic       used;
	logic       same;
	logic [7:0] byte_nxt;
	logic [7:0] free_b;
	logic [7:0] cnt_m;
	logic [2:0] ff_pos;
	logic [9:0] ff_slot;
	logic       searched;
	scan_t      scan_nxt;

	always_comb begin
		hit   = scan_in.vld && scan_in.upd && ({1'b0, scan_in.byte_sel} == IDX7);
		bit_m = 8'h80 >> scan_in.bit_pos;
		used  = |(byte_q & bit_m);
		same  = hit && (scan_in.rel ? !used : used);
		if (hit && !same) begin
			byte_nxt = scan_in.rel ? (byte_q & ~bit_m) : (byte_q | bit_m);
		end else begin
			byte_nxt = byte_q;
		end
		free_b = ~byte_nxt;
		ff_pos = '0;
		for (int j = 7; j >= 0; j--) begin
			if (free_b[7 - j]) begin
				ff_pos = 3'(j);
			end
		end
		for (int j = 0; j < 8; j++) begin
			cnt_m[7 - j] = (BASE + 10'(j)) < {1'b0, slot_count};
		end
		ff_slot  = BASE + {7'b0, ff_pos} + 10'd1;
		searched = IDX7 < {1'b0, map_bytes};

		scan_nxt = scan_in;
		if (same) begin
			scan_nxt.status = ST_SAME;
		end
		if (!scan_in.found && searched && (|free_b)) begin
			scan_nxt.found = 1'b1;
			scan_nxt.first = ff_slot[8:0];
		end
		scan_nxt.free_seen = scan_in.free_seen || (|(free_b & cnt_m));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
			scan_q <= '0;
		end else begin
			scan_q <= scan_nxt;
			if (scan_in.vld) begin
				byte_q <= byte_nxt;
			end
		end
	end

	assign scan_out = scan_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sba_check.sv =====
// port-level checks for the slot bitmap allocator, bound to the top level
// depends on slot_bitmap_allocator_top_assert.svh
`default_nettype none

`include "slot_bitmap_allocator_top_assert.svh"

module sba_check (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [1:0] status,
	input wire logic [8:0] first_free,
	input wire logic       full_res
);

	logic unused_ok;
	assign unused_ok = ^{status, first_free, full_res};

	// a result only comes out for a request in flight
	`SBA_ASSERT(a_done_busy, done |-> busy)
	// one result per request, never two in a row
	`SBA_ASSERT(a_done_single, done |=> !done)
	// a taken request holds off the next one
	`SBA_ASSERT(a_accept_busy, (start && !busy) |=> busy)
	// busy ends only right after the result word
	`SBA_ASSERT_ALWAYS(a_busy_end, (arst_n && $fell(busy)) |-> $past(done))

endmodule

bind slot_bitmap_allocator_top sba_check u_sba_check (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for slot_bitmap_allocator_top: drives claim/release/query words and
// predicts status, first free slot and full flag in a scoreboard class
// depends on sba_pkg and slot_bitmap_allocator_top
`timescale 1ns / 100ps

module tb;
	import sba_pkg::*;

	localparam int NUM_BLOCKS = 9;
	localparam int GAP_MAX    = 20;
	localparam int STALL_MAX  = 1000;

	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_BOTH
	} traffic_t;

	typedef struct packed {
		status_t    status;
		logic [8:0] first_free;
		logic       full_res;
	} alloc_result_t;

	class slot_map_scoreboard;
		bit [7:0]      occ [MAP_BYTES_DEF];
		int unsigned   map_bytes_reg;
		int unsigned   slot_count_reg;
		alloc_result_t expected_allocs [$];
		int            errors;
		int            n_words;
		int            n_results;
		int            n_status [3];
		int            n_full;
		int            n_none_free;

		function new();
			foreach (occ[i]) occ[i] = 8'h00;
			map_bytes_reg  = MAP_BYTES_RST;
			slot_count_reg = SLOT_COUNT_RST;
			errors         = 0;
			n_words        = 0;
			n_results      = 0;
			n_full         = 0;
			n_none_free    = 0;
			foreach (n_status[i]) n_status[i] = 0;
		endfunction

		function void set_reg(reg_idx_t idx, bit [8:0] value);
			if (idx == REG_MAP_BYTES)
				map_bytes_reg = value[5:0];
			else
				slot_count_reg = value;
		endfunction

		function int unsigned eff_bytes();
			return (map_bytes_reg > MAP_BYTES_DEF) ? MAP_BYTES_DEF : map_bytes_reg;
		endfunction

		function bit is_used(int unsigned idx);
			return occ[idx / 8][7 - (idx % 8)];
		endfunction

		function bit [8:0] scan_first_free();
			for (int unsigned i = 0; i < eff_bytes() * 8; i++)
				if (!is_used(i))
					return 9'(i + 1);
			return 9'd0;
		endfunction

		function bit scan_full();
			int unsigned n;
			n = (slot_count_reg > MAP_BYTES_DEF * 8) ? MAP_BYTES_DEF * 8 : slot_count_reg;
			for (int unsigned i = 0; i < n; i++)
				if (!is_used(i))
					return 1'b0;
			return 1'b1;
		endfunction

		function int pending();
			return expected_allocs.size();
		endfunction

		// accepted word: update the map and queue the expected result
		function void note_word(logic [1:0] k_raw, logic [8:0] slot);
			kind_t         k;
			status_t       st;
			int unsigned   idx;
			bit            used;
			alloc_result_t r;
			k  = kind_t'(k_raw);
			st = ST_OK;
			if (k == KIND_CLAIM || k == KIND_RELEASE) begin
				if (slot == 9'd0 || slot > eff_bytes() * 8) begin
					st = ST_RANGE;
				end else begin
					idx  = slot - 1;
					used = is_used(idx);
					if (k == KIND_CLAIM) begin
						if (used)
							st = ST_SAME;
						else
							occ[idx / 8][7 - (idx % 8)] = 1'b1;
					end else begin
						if (!used)
							st = ST_SAME;
						else
							occ[idx / 8][7 - (idx % 8)] = 1'b0;
					end
				end
			end
			r.status     = st;
			r.first_free = scan_first_free();
			r.full_res   = scan_full();
			expected_allocs.push_back(r);
			n_words++;
			n_status[st]++;
			if (r.full_res)
				n_full++;
			if (r.first_free == 9'd0)
				n_none_free++;
		endfunction

		function void check_word(logic [1:0] st, logic [8:0] ff, logic fr);
			alloc_result_t e;
			n_results++;
			if (expected_allocs.size() == 0) begin
				$display("%0t unexpected result: status %0d first_free %0d full_res %0d",
					$time, st, ff, fr);
				errors++;
				return;
			end
			e = expected_allocs.pop_front();
			if (st !== e.status) begin
				$display("%0t status mismatch: expected %0d actual %0d", $time, e.status, st);
				errors++;
			end
			if (ff !== e.first_free) begin
				$display("%0t first_free mismatch: expected %0d actual %0d",
					$time, e.first_free, ff);
				errors++;
			end
			if (fr !== e.full_res) begin
				$display("%0t full_res mismatch: expected %0d actual %0d", $time, e.full_res, fr);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_idx;
	logic [8:0] cfg_wdata;
	logic       start;
	logic [1:0] kind;
	logic [8:0] slot_number;
	logic       busy;
	logic       done;
	logic [1:0] status;
	logic [8:0] first_free;
	logic       full_res;

	slot_map_scoreboard sb;
	int                 n_cfg_writes = 0;
	int                 stall_cycles = 0;

	slot_bitmap_allocator_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.start       (start),
		.kind        (kind),
		.slot_number (slot_number),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.first_free  (first_free),
		.full_res    (full_res)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_word(kind, slot_number);
			if (done)
				sb.check_word(status, first_free, full_res);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_MAX) begin
				$display("%0t timeout: no word or result for %0d cycles", $time, STALL_MAX);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send_word(kind_t k, bit [8:0] s, int idle_pct);
		int gap;
		gap = 0;
		while (gap < GAP_MAX && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		kind        <= k;
		slot_number <= s;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// hold off until the block is idle and every result is in
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_regs(bit [5:0] mb, bit [8:0] sc);
		bit [8:0] wd;
		wd      = 9'(mb);
		wd[8:6] = 3'($urandom_range(7));
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_MAP_BYTES;
		cfg_wdata <= wd;
		@(posedge clk);
		sb.set_reg(REG_MAP_BYTES, wd);
		cfg_idx   <= REG_SLOT_COUNT;
		cfg_wdata <= sc;
		@(posedge clk);
		sb.set_reg(REG_SLOT_COUNT, sc);
		cfg_we <= 1'b0;
		n_cfg_writes += 2;
	endtask

	task automatic pick_word(traffic_t mix, output kind_t k, output bit [8:0] s);
		int unsigned span;
		int unsigned r;
		span = (sb.eff_bytes() == 0) ? 8 : sb.eff_bytes() * 8;
		r    = $urandom_range(99);
		s    = 9'($urandom_range(span, 1));
		if (r < 10) begin
			k = kind_t'($urandom_range(3));
			s = 9'($urandom_range(511));
		end else if (mix == MIX_FILL) begin
			if (r < 65) begin
				k = KIND_CLAIM;
				if (sb.scan_first_free() != 9'd0)
					s = sb.scan_first_free();
			end else if (r < 85) begin
				k = KIND_RELEASE;
			end else begin
				k = ($urandom_range(1) != 0) ? KIND_QUERY : KIND_SPARE;
			end
		end else if (mix == MIX_DRAIN) begin
			if (r < 70)
				k = KIND_RELEASE;
			else if (r < 85)
				k = KIND_CLAIM;
			else
				k = KIND_QUERY;
		end else begin
			if (r < 50)
				k = KIND_CLAIM;
			else if (r < 85)
				k = KIND_RELEASE;
			else
				k = KIND_QUERY;
		end
	endtask

	initial begin
		int       blk_map   [NUM_BLOCKS] = '{2, 1, 0, 63, 32, 4, 33, 0, 8};
		int       blk_slots [NUM_BLOCKS] = '{16, 0, 5, 511, 256, 32, 200, 0, 64};
		int       blk_words [NUM_BLOCKS] = '{60, 40, 30, 280, 80, 80, 100, 100, 100};
		traffic_t blk_mix   [NUM_BLOCKS] = '{MIX_FILL, MIX_DRAIN, MIX_BOTH, MIX_FILL,
			MIX_DRAIN, MIX_FILL, MIX_BOTH, MIX_BOTH, MIX_DRAIN};
		kind_t    k;
		bit [8:0] s;
		int       idle_pct;

		sb = new();
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_idx     <= REG_MAP_BYTES;
		cfg_wdata   <= 9'd0;
		start       <= 1'b0;
		kind        <= KIND_QUERY;
		slot_number <= 9'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: range edges, repeats, unused kind, tiny and empty maps
		send_word(KIND_QUERY, 9'd0, 19);
		send_word(KIND_SPARE, 9'd511, 19);
		send_word(KIND_CLAIM, 9'd0, 19);
		send_word(KIND_CLAIM, 9'd257, 19);
		send_word(KIND_RELEASE, 9'd511, 19);
		send_word(KIND_CLAIM, 9'd1, 19);
		send_word(KIND_CLAIM, 9'd1, 19);
		send_word(KIND_CLAIM, 9'd256, 19);
		send_word(KIND_RELEASE, 9'd256, 19);
		send_word(KIND_RELEASE, 9'd256, 19);
		send_word(KIND_RELEASE, 9'd2, 19);
		send_word(KIND_CLAIM, 9'd170, 19);
		send_word(KIND_CLAIM, 9'd85, 19);
		wait_idle();
		write_regs(6'd1, 9'd8);
		for (int i = 1; i <= 8; i++)
			send_word(KIND_CLAIM, 9'(i), 19);
		send_word(KIND_RELEASE, 9'd9, 19);
		send_word(KIND_CLAIM, 9'd8, 19);
		wait_idle();
		write_regs(6'd0, 9'd0);
		send_word(KIND_CLAIM, 9'd1, 19);
		send_word(KIND_QUERY, 9'd0, 19);

		for (int b = 0; b < NUM_BLOCKS; b++) begin
			idle_pct = (b < 4) ? 19 : ((b < 7) ? 74 : 0);
			wait_idle();
			if (b == 7)
				write_regs(6'($urandom_range(63)), 9'($urandom_range(511)));
			else
				write_regs(6'(blk_map[b]), 9'(blk_slots[b]));
			for (int i = 0; i < blk_words[b]; i++) begin
				pick_word(blk_mix[b], k, s);
				send_word(k, s, idle_pct);
			end
		end

		wait_idle();
		repeat (MAP_BYTES_DEF + 4) @(posedge clk);

		$display("covered %0d words and %0d results over %0d register writes",
			sb.n_words, sb.n_results, n_cfg_writes);
		$display("status ok %0d, repeat %0d, out of range %0d; full %0d, no free slot %0d",
			sb.n_status[ST_OK], sb.n_status[ST_SAME], sb.n_status[ST_RANGE],
			sb.n_full, sb.n_none_free);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sba_pkg.sv
hw/rtl/sba_cell.sv
hw/rtl/slot_bitmap_allocator_top.sv
hw/rtl/sba_check.sv
tb/tb.sv
